// ===== hw/rtl/sptw_pkg.sv =====
// Shared types and constants of the Sv39 page-table walker.
// Used by sptw_locate, sptw_store and sv39_page_table_walker_core; no dependencies.
`default_nettype none

package sptw_pkg;

    // Table store geometry
    localparam int STORE_WORDS = 4096;
    localparam int AW          = $clog2(STORE_WORDS);
    // Pages the window may touch; the last one lies wholly outside the store
    localparam int WIN_PAGES   = (STORE_WORDS >> 9) + 1;
    localparam int OFF_W       = $clog2(WIN_PAGES);

    // Field widths
    localparam int PAGE_W  = 44;
    localparam int LIMIT_W = 40;
    localparam int VA_W    = 64;
    localparam int PTE_W   = 64;
    localparam int WIDX_W  = 12;
    localparam int BASE_W  = 56;
    localparam int FLAGS_W = 10;
    localparam int CFG_W   = 44;
    localparam int VPN_W   = 9;

    // PTE bit positions
    localparam int PTE_V_BIT = 0;
    localparam int PTE_U_BIT = 4;
    localparam int PTE_PPN_LSB = 10;

    // Reset value of the address limit
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 40'h40_0000_0000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROOT  = 2'd0,
        CFG_WIN   = 2'd1,
        CFG_LIMIT = 2'd2
    } t_cfg_idx;

    // Function codes
    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_XLATE = 2'd1,
        FN_CLRU  = 2'd2
    } t_func;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LIMIT     = 3'd1,
        ST_UPPER_INV = 3'd2,
        ST_LEAF_INV  = 3'd3,
        ST_NOT_USER  = 3'd4,
        ST_WINDOW    = 3'd5
    } t_status;

    // Store access request
    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [PTE_W-1:0] wdata;
        logic             re;
        logic [AW-1:0]    raddr;
    } t_mem_req;

    // Window lookup result
    typedef struct packed {
        logic          ok;
        logic [AW-1:0] word;
    } t_loc;

endpackage

`default_nettype wire

// ===== hw/rtl/sptw_locate.sv =====
// Maps a table page and entry index onto a word of the local table store.
// Depends on sptw_pkg.
`default_nettype none

module sptw_locate (
    input  wire logic [sptw_pkg::PAGE_W-1:0] i_page,
    input  wire logic [sptw_pkg::PAGE_W-1:0] i_win_base,
    input  wire logic [sptw_pkg::VPN_W-1:0]  i_idx,
    output sptw_pkg::t_loc                   o_loc
);

    logic [sptw_pkg::PAGE_W:0]                     diff;
    logic                                          page_ok;
    logic [sptw_pkg::OFF_W+sptw_pkg::VPN_W-1:0]    full;

    // Page offset from the window base; borrow means below the window
    assign diff    = {1'b0, i_page} - {1'b0, i_win_base};
    assign page_ok = !diff[sptw_pkg::PAGE_W] &&
                     (diff[sptw_pkg::PAGE_W-1:0] <
                      sptw_pkg::PAGE_W'(sptw_pkg::WIN_PAGES));

    // Word number inside the store
    assign full = {diff[sptw_pkg::OFF_W-1:0], i_idx};

    assign o_loc.ok   = page_ok &&
                        (full < (sptw_pkg::OFF_W+sptw_pkg::VPN_W)'(sptw_pkg::STORE_WORDS));
    assign o_loc.word = full[sptw_pkg::AW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/sptw_store.sv =====
// Local page-table word store: one write and one registered read per cycle.
// Depends on sptw_pkg. Contents are undefined until written.
`default_nettype none

module sptw_store (
    input  wire logic                        i_clk,
    input  wire sptw_pkg::t_mem_req          i_req,
    output logic [sptw_pkg::PTE_W-1:0]       o_rdata
);

    logic [sptw_pkg::PTE_W-1:0] mem [sptw_pkg::STORE_WORDS];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sv39_page_table_walker_core.sv =====
// Sv39 three-level page-table walker over a local table store.
// Depends on sptw_pkg, sptw_locate and sptw_store.
//
//  channel   | handshake        | payload
//  ----------+------------------+--------------------------------------------
//  command   | start / busy     | i_func, i_virt_addr, i_word_index, i_word_value
//  result    | o_done (strobe)  | o_status, o_phys_base, o_leaf_flags
//  config    | i_cfg_we         | i_cfg_idx, i_cfg_wdata
//
// A command is taken when start is high and busy is low. Writes, unused codes and
// limit rejects give their result in the cycle after acceptance. A walk passes two
// states per level (address check, then the store read), so a full translate or
// a clear-user goes through both states at each of the three levels before its
// result; an early failure ends sooner. Each of the three dependent store reads
// sits behind its own window check. Reset is synchronous and active low; the store
// itself is not cleared. Results cannot be stalled.
`default_nettype none

module sv39_page_table_walker_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // command
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_func,
    input  wire logic [sptw_pkg::VA_W-1:0]      i_virt_addr,
    input  wire logic [sptw_pkg::WIDX_W-1:0]    i_word_index,
    input  wire logic [sptw_pkg::PTE_W-1:0]     i_word_value,
    // result
    output logic                                o_done,
    output logic [2:0]                          o_status,
    output logic [sptw_pkg::BASE_W-1:0]         o_phys_base,
    output logic [sptw_pkg::FLAGS_W-1:0]        o_leaf_flags,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_idx,
    input  wire logic [sptw_pkg::CFG_W-1:0]     i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_DATA
    } t_state;

    t_state                               r_state;
    logic [1:0]                           r_level;
    logic [sptw_pkg::PAGE_W-1:0]          r_page;
    logic [3*sptw_pkg::VPN_W-1:0]         r_vpn;
    logic                                 r_clru;
    logic [sptw_pkg::AW-1:0]              r_word;

    logic [sptw_pkg::PAGE_W-1:0]          r_root;
    logic [sptw_pkg::PAGE_W-1:0]          r_win;
    logic [sptw_pkg::LIMIT_W-1:0]         r_limit;

    logic                                 r_done;
    sptw_pkg::t_status                    r_status;
    logic [sptw_pkg::BASE_W-1:0]          r_base;
    logic [sptw_pkg::FLAGS_W-1:0]         r_flags;

    logic [sptw_pkg::VPN_W-1:0]           idx;
    sptw_pkg::t_loc                       loc;
    sptw_pkg::t_mem_req                   req;
    logic [sptw_pkg::PTE_W-1:0]           rdata;
    logic [sptw_pkg::PTE_W-1:0]           pte_clr;
    logic [sptw_pkg::AW+sptw_pkg::WIDX_W-1:0] widx_ext;
    logic                                 widx_ok;
    logic                                 over_limit;
    logic                                 accept;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // Write index range check
    assign widx_ext = (sptw_pkg::AW+sptw_pkg::WIDX_W)'(i_word_index);
    assign widx_ok  = (widx_ext < (sptw_pkg::AW+sptw_pkg::WIDX_W)'(sptw_pkg::STORE_WORDS));

    // Virtual address limit check
    assign over_limit = (i_virt_addr[sptw_pkg::VA_W-1:sptw_pkg::LIMIT_W] != '0) ||
                        (i_virt_addr[sptw_pkg::LIMIT_W-1:0] >= r_limit);

    // Table index for the current level
    always_comb begin
        case (r_level)
            2'd2:    idx = r_vpn[3*sptw_pkg::VPN_W-1:2*sptw_pkg::VPN_W];
            2'd1:    idx = r_vpn[2*sptw_pkg::VPN_W-1:sptw_pkg::VPN_W];
            default: idx = r_vpn[sptw_pkg::VPN_W-1:0];
        endcase
    end

    sptw_locate u_locate (
        .i_page     (r_page),
        .i_win_base (r_win),
        .i_idx      (idx),
        .o_loc      (loc)
    );

    // Leaf with user bit removed
    always_comb begin
        pte_clr = rdata;
        pte_clr[sptw_pkg::PTE_U_BIT] = 1'b0;
    end

    // Store requests: command writes, walk reads, clear-user write-back
    always_comb begin
        req.we    = 1'b0;
        req.waddr = r_word;
        req.wdata = pte_clr;
        req.re    = 1'b0;
        req.raddr = loc.word;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_func == sptw_pkg::FN_WRITE) && widx_ok) begin
                    req.we    = 1'b1;
                    req.waddr = widx_ext[sptw_pkg::AW-1:0];
                    req.wdata = i_word_value;
                end
            end
            S_ADDR: begin
                req.re = loc.ok;
            end
            S_DATA: begin
                req.we = (r_level == 2'd0) && r_clru;
            end
            default: begin
            end
        endcase
    end

    sptw_store u_store (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= '0;
            r_win   <= '0;
            r_limit <= sptw_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sptw_pkg::CFG_ROOT:  r_root  <= i_cfg_wdata;
                sptw_pkg::CFG_WIN:   r_win   <= i_cfg_wdata;
                sptw_pkg::CFG_LIMIT: r_limit <= i_cfg_wdata[sptw_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Walk sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_status <= sptw_pkg::ST_OK;
            r_base   <= '0;
            r_flags  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= sptw_pkg::ST_OK;
                        r_base   <= '0;
                        r_flags  <= '0;
                        r_level  <= 2'd2;
                        r_page   <= r_root;
                        r_vpn    <= i_virt_addr[38:12];
                        r_clru   <= (i_func == sptw_pkg::FN_CLRU);
                        case (i_func)
                            sptw_pkg::FN_WRITE: begin
                                r_done <= 1'b1;
                                if (!widx_ok) begin
                                    r_status <= sptw_pkg::ST_WINDOW;
                                end
                            end
                            sptw_pkg::FN_XLATE, sptw_pkg::FN_CLRU: begin
                                if (over_limit) begin
                                    r_done   <= 1'b1;
                                    r_status <= sptw_pkg::ST_LIMIT;
                                end else begin
                                    r_state <= S_ADDR;
                                end
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_ADDR: begin
                    r_word <= loc.word;
                    if (loc.ok) begin
                        r_state <= S_DATA;
                    end else begin
                        r_status <= sptw_pkg::ST_WINDOW;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_DATA: begin
                    if (r_level != 2'd0) begin
                        // upper level: valid entries always point onward
                        if (!rdata[sptw_pkg::PTE_V_BIT]) begin
                            r_status <= sptw_pkg::ST_UPPER_INV;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_page  <= rdata[sptw_pkg::PTE_PPN_LSB +: sptw_pkg::PAGE_W];
                            r_level <= r_level - 2'd1;
                            r_state <= S_ADDR;
                        end
                    end else begin
                        // leaf
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_clru) begin
                            r_flags <= pte_clr[sptw_pkg::FLAGS_W-1:0];
                            r_base  <= {rdata[sptw_pkg::PTE_PPN_LSB +: sptw_pkg::PAGE_W], 12'd0};
                        end else begin
                            r_flags <= rdata[sptw_pkg::FLAGS_W-1:0];
                            if (!rdata[sptw_pkg::PTE_V_BIT]) begin
                                r_status <= sptw_pkg::ST_LEAF_INV;
                            end else if (!rdata[sptw_pkg::PTE_U_BIT]) begin
                                r_status <= sptw_pkg::ST_NOT_USER;
                            end else begin
                                r_base <= {rdata[sptw_pkg::PTE_PPN_LSB +: sptw_pkg::PAGE_W],
                                           12'd0};
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_phys_base  = r_base;
    assign o_leaf_flags = r_flags;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for sv39_page_table_walker_core: builds page tables
// through write transactions, walks them with translate and clear-user commands.
// Depends on sptw_pkg and the walker RTL; a scoreboard class predicts every result.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sptw_pkg::*;

    localparam logic [PAGE_W-1:0]  PAGE_MAX     = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_TOP    = 40'h80_0000_0000;
    localparam logic [1:0]         FN_UNUSED    = 2'd3;
    localparam int                 STALL_LIMIT  = 1000;
    localparam int                 DRAIN_CYCLES = 10;

    typedef struct {
        t_status             status;
        logic [BASE_W-1:0]   base;
        logic [FLAGS_W-1:0]  flags;
    } walk_result_t;

    // Predicts walker results and holds the results still to come
    class walk_scoreboard;
        logic [PTE_W-1:0]   pte_mem [STORE_WORDS];
        bit                 written [STORE_WORDS];
        logic [PAGE_W-1:0]  root_pg;
        logic [PAGE_W-1:0]  win_pg;
        logic [LIMIT_W-1:0] va_limit;
        walk_result_t       pending_q [$];
        int                 errors;

        function new();
            root_pg  = '0;
            win_pg   = '0;
            va_limit = LIMIT_RST;
            errors   = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
            case (idx)
                CFG_ROOT:  root_pg  = val[PAGE_W-1:0];
                CFG_WIN:   win_pg   = val[PAGE_W-1:0];
                CFG_LIMIT: va_limit = val[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Table page plus entry index to a store word; 0 when outside the window
        function bit slot(input logic [PAGE_W-1:0] page, input logic [VPN_W-1:0] idx,
                          output logic [AW-1:0] word);
            logic [63:0] off;
            word = '0;
            if (page < win_pg) return 1'b0;
            off = 64'(page - win_pg);
            if (off >= 64'(WIN_PAGES)) return 1'b0;
            off = off * 64'd512 + 64'(idx);
            if (off >= 64'(STORE_WORDS)) return 1'b0;
            word = off[AW-1:0];
            return 1'b1;
        endfunction

        // Three-level walk; commit applies the clear-user write-back.
        // unsafe flags a read of a word that was never written.
        function walk_result_t walk(input logic [1:0] fn, input logic [VA_W-1:0] va,
                                    input bit commit, output bit unsafe);
            walk_result_t      r;
            logic [PAGE_W-1:0] page;
            logic [PTE_W-1:0]  pte;
            logic [AW-1:0]     word;
            r.status = ST_OK;
            r.base   = '0;
            r.flags  = '0;
            unsafe   = 1'b0;
            if (va >= VA_W'(va_limit)) begin
                r.status = ST_LIMIT;
                return r;
            end
            page = root_pg;
            for (int lvl = 2; lvl >= 0; lvl--) begin
                if (!slot(page, va[12 + 9*lvl +: VPN_W], word)) begin
                    r.status = ST_WINDOW;
                    return r;
                end
                unsafe |= !written[word];
                pte = pte_mem[word];
                if (lvl > 0) begin
                    // upper entries are pointers whatever their R/W/X bits
                    if (!pte[PTE_V_BIT]) begin
                        r.status = ST_UPPER_INV;
                        return r;
                    end
                    page = pte[PTE_PPN_LSB +: PAGE_W];
                end else begin
                    if (fn == FN_CLRU) begin
                        pte[PTE_U_BIT] = 1'b0;
                        if (commit) pte_mem[word] = pte;
                    end
                    r.flags = pte[FLAGS_W-1:0];
                    if (fn == FN_CLRU || (pte[PTE_V_BIT] && pte[PTE_U_BIT]))
                        r.base = {pte[PTE_PPN_LSB +: PAGE_W], 12'h000};
                    else if (!pte[PTE_V_BIT])
                        r.status = ST_LEAF_INV;
                    else
                        r.status = ST_NOT_USER;
                end
            end
            return r;
        endfunction

        // Accepted command transaction: update state, queue its result
        function void note(input logic [1:0] fn, input logic [VA_W-1:0] va,
                           input logic [WIDX_W-1:0] widx, input logic [PTE_W-1:0] wval);
            walk_result_t r;
            bit           unused;
            r.status = ST_OK;
            r.base   = '0;
            r.flags  = '0;
            if (fn == FN_WRITE) begin
                pte_mem[widx] = wval;
                written[widx] = 1'b1;
            end else if (fn == FN_XLATE || fn == FN_CLRU) begin
                r = walk(fn, va, 1'b1, unused);
            end
            pending_q.push_back(r);
        endfunction

        // Result transaction against the oldest prediction
        function void check(input logic [2:0] status, input logic [BASE_W-1:0] base,
                            input logic [FLAGS_W-1:0] flags);
            walk_result_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, status %0d base %h flags %h",
                         $time, status, base, flags);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (status !== e.status) begin
                $display("%0t: status expected %0d, actual %0d", $time, e.status, status);
                errors++;
            end
            if (base !== e.base) begin
                $display("%0t: phys_base expected %h, actual %h", $time, e.base, base);
                errors++;
            end
            if (flags !== e.flags) begin
                $display("%0t: leaf_flags expected %h, actual %h", $time, e.flags, flags);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic [1:0]          i_func       = '0;
    logic [VA_W-1:0]     i_virt_addr  = '0;
    logic [WIDX_W-1:0]   i_word_index = '0;
    logic [PTE_W-1:0]    i_word_value = '0;
    logic                o_done;
    logic [2:0]          o_status;
    logic [BASE_W-1:0]   o_phys_base;
    logic [FLAGS_W-1:0]  o_leaf_flags;
    logic                i_cfg_we     = 1'b0;
    logic [1:0]          i_cfg_idx    = '0;
    logic [CFG_W-1:0]    i_cfg_wdata  = '0;

    walk_scoreboard      sb = new();
    logic [VA_W-1:0]     recent_va [$];
    int                  n_sent    = 0;
    int                  stall_cnt = 0;
    bit                  calm      = 1'b0;

    sv39_page_table_walker_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_virt_addr  (i_virt_addr),
        .i_word_index (i_word_index),
        .i_word_value (i_word_value),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_phys_base  (o_phys_base),
        .o_leaf_flags (o_leaf_flags),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check(o_status, o_phys_base, o_leaf_flags);
    end

    // Watchdog: too long without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PTE_W-1:0] make_pte(input logic [9:0] hi,
                                                  input logic [PAGE_W-1:0] ppn,
                                                  input logic [9:0] flags);
        return {hi, ppn, flags};
    endfunction

    // Mostly a page inside the window, sometimes just outside or anywhere
    function automatic logic [PAGE_W-1:0] near_page();
        logic [PAGE_W-1:0] room;
        room = PAGE_MAX - sb.win_pg;
        if ($urandom_range(9) != 0)
            return sb.win_pg + PAGE_W'($urandom_range((room < 7) ? int'(room) : 7));
        case ($urandom_range(2))
            0:       return (room >= 8) ? sb.win_pg + 44'd8 : sb.win_pg - 44'd1;
            1:       return (sb.win_pg != 0) ? sb.win_pg - 44'd1 : sb.win_pg + 44'd8;
            default: return PAGE_W'(rand64());
        endcase
    endfunction

    function automatic logic [VA_W-1:0] pick_va();
        logic [VA_W-1:0] v;
        v = rand64();
        if (sb.va_limit != 0 && $urandom_range(9) != 0) v = v % VA_W'(sb.va_limit);
        return v;
    endfunction

    function automatic logic [PTE_W-1:0] upper_pte();
        logic [PTE_W-1:0] v;
        v = rand64();
        v[PTE_V_BIT] = ($urandom_range(9) != 0);
        v[PTE_PPN_LSB +: PAGE_W] = near_page();
        return v;
    endfunction

    function automatic logic [PTE_W-1:0] leaf_pte();
        logic [PTE_W-1:0] v;
        v = rand64();
        v[PTE_V_BIT] = ($urandom_range(4) != 0);
        v[PTE_U_BIT] = ($urandom_range(2) != 0);
        return v;
    endfunction

    // One command transaction with a random lead-in gap
    task automatic send_cmd(input logic [1:0] fn, input logic [VA_W-1:0] va,
                            input logic [WIDX_W-1:0] widx, input logic [PTE_W-1:0] wval);
        int gap;
        if ($urandom_range(29) == 0) calm = !calm;
        gap = calm ? 0 : $urandom_range(5);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_func       = fn;
        i_virt_addr  = va;
        i_word_index = widx;
        i_word_value = wval;
        do @(posedge i_clk); while (busy);
        sb.note(fn, va, widx, wval);
        if (fn != FN_UNUSED) n_sent++;
    endtask

    // Hold off until every predicted result has arrived
    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_q.size() != 0 || busy) @(negedge i_clk);
    endtask

    task automatic configure(input logic [PAGE_W-1:0] root, input logic [PAGE_W-1:0] win,
                             input logic [LIMIT_W-1:0] limit);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = CFG_ROOT;
        i_cfg_wdata = root;
        @(negedge i_clk);
        i_cfg_idx   = CFG_WIN;
        i_cfg_wdata = win;
        @(negedge i_clk);
        // upper bits beyond the 40-bit limit are junk
        i_cfg_idx   = CFG_LIMIT;
        i_cfg_wdata = {4'($urandom), limit};
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_reg(CFG_ROOT, root);
        sb.set_reg(CFG_WIN, win);
        sb.set_reg(CFG_LIMIT, CFG_W'(limit));
    endtask

    // Walk command, replaced by a write when it would read an unwritten word
    task automatic issue_walk(input logic [1:0] fn, input logic [VA_W-1:0] va);
        bit unsafe;
        void'(sb.walk(fn, va, 1'b0, unsafe));
        if (unsafe)
            send_cmd(FN_WRITE, rand64(), WIDX_W'($urandom), upper_pte());
        else
            send_cmd(fn, va, WIDX_W'($urandom), rand64());
    endtask

    // Fill in the path of a virtual address, then walk it
    task automatic build_walk();
        logic [VA_W-1:0]   va;
        logic [PAGE_W-1:0] page;
        logic [AW-1:0]     word;
        logic [PTE_W-1:0]  pte;
        va   = pick_va();
        page = sb.root_pg;
        if (va < VA_W'(sb.va_limit)) begin
            for (int lvl = 2; lvl >= 0; lvl--) begin
                if (!sb.slot(page, va[12 + 9*lvl +: VPN_W], word)) break;
                if (!sb.written[word] || $urandom_range(3) == 0)
                    send_cmd(FN_WRITE, rand64(), word, (lvl > 0) ? upper_pte() : leaf_pte());
                pte = sb.pte_mem[word];
                if (lvl == 0 || !pte[PTE_V_BIT]) break;
                page = pte[PTE_PPN_LSB +: PAGE_W];
            end
        end
        issue_walk(($urandom_range(3) == 0) ? FN_CLRU : FN_XLATE, va);
        recent_va.push_back(va);
        if (recent_va.size() > 32) void'(recent_va.pop_front());
    endtask

    task automatic noise_item();
        case ($urandom_range(4))
            0:       send_cmd(FN_WRITE, rand64(), WIDX_W'($urandom), rand64());
            1:       send_cmd(FN_WRITE, rand64(), WIDX_W'($urandom), upper_pte());
            2:       send_cmd(FN_UNUSED, rand64(), WIDX_W'($urandom), rand64());
            3:       issue_walk($urandom_range(1) ? FN_CLRU : FN_XLATE, rand64());
            default: issue_walk($urandom_range(1) ? FN_CLRU : FN_XLATE, pick_va());
        endcase
    endtask

    task automatic run_phase(input logic [PAGE_W-1:0] root, input logic [PAGE_W-1:0] win,
                             input logic [LIMIT_W-1:0] limit, input int n_items);
        int goal;
        int pick;
        configure(root, win, limit);
        goal = n_sent + n_items;
        while (n_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 60)
                build_walk();
            else if (pick < 75 && recent_va.size() != 0)
                issue_walk($urandom_range(1) ? FN_CLRU : FN_XLATE,
                           recent_va[$urandom_range(recent_va.size() - 1)]);
            else
                noise_item();
            if ($urandom_range(49) == 0) wait_idle();
        end
    endtask

    initial begin
        logic [PAGE_W-1:0] wpg;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under reset settings: root page 0, window at page 0
        send_cmd(FN_WRITE, '0, 12'd0, make_pte(10'h3FF, 44'd1, 10'h0C1));
        // R/W/X set on an upper entry: still a pointer
        send_cmd(FN_WRITE, '0, 12'd512, make_pte(10'h000, 44'd2, 10'h00F));
        send_cmd(FN_WRITE, '0, 12'd1024, make_pte(10'h000, PAGE_MAX, 10'h3FF));
        send_cmd(FN_XLATE, 64'h0, '0, '0);
        send_cmd(FN_CLRU, 64'h0, '0, '0);
        // user bit now gone
        send_cmd(FN_XLATE, 64'h0, '0, '0);
        // leaf not valid
        send_cmd(FN_WRITE, '0, 12'd1025, make_pte(10'h000, 44'h123, 10'h010));
        send_cmd(FN_XLATE, 64'h1000, '0, '0);
        // upper entry not valid
        send_cmd(FN_WRITE, '0, 12'd513, 64'h0);
        send_cmd(FN_XLATE, 64'h20_0000, '0, '0);
        // pointer just past the window end, then to the top page
        send_cmd(FN_WRITE, '0, 12'd2, make_pte(10'h000, 44'd8, 10'h001));
        send_cmd(FN_XLATE, 64'h8000_0000, '0, '0);
        send_cmd(FN_WRITE, '0, 12'd3, make_pte(10'h000, PAGE_MAX, 10'h001));
        send_cmd(FN_CLRU, 64'hC000_0000, '0, '0);
        // highest address below the limit, through a self-pointing root entry
        send_cmd(FN_WRITE, '0, 12'd255, make_pte(10'h000, 44'd0, 10'h0CF));
        send_cmd(FN_WRITE, '0, 12'd511, make_pte(10'h000, 44'd7, 10'h001));
        send_cmd(FN_WRITE, '0, 12'd4095, '1);
        send_cmd(FN_XLATE, 64'h3F_FFFF_FFFF, '0, '0);
        // at and far beyond the limit
        send_cmd(FN_XLATE, 64'h40_0000_0000, '0, '0);
        send_cmd(FN_CLRU, '1, '0, '0);
        // unused function code
        send_cmd(FN_UNUSED, rand64(), WIDX_W'($urandom), rand64());

        // Random part over several settings
        run_phase(44'd0, 44'd0, LIMIT_TOP, 150);
        run_phase(PAGE_MAX, PAGE_MAX, LIMIT_TOP, 150);
        wpg = PAGE_W'(rand64()) >> 1;
        run_phase(wpg + PAGE_W'($urandom_range(7)), wpg,
                  LIMIT_W'(rand64() % (64'(LIMIT_TOP) + 64'd1)), 150);
        // limit zero rejects every walk
        run_phase(PAGE_W'(rand64()), PAGE_W'(rand64()), '0, 30);
        // root table one page below the window
        wpg = PAGE_W'(rand64()) | 44'd1;
        run_phase(wpg - 44'd1, wpg, LIMIT_TOP, 30);
        run_phase(44'd5, 44'd0, LIMIT_RST, 150);
        wpg = PAGE_W'(rand64()) >> 1;
        run_phase(wpg + 44'd3, wpg, LIMIT_W'(rand64() % (64'(LIMIT_TOP) + 64'd1)), 150);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
